/* rtl/lcdbw_pkg.sv */
// ---------------------------------------------------------------------------
// lcdbw_pkg
// shared types and constants for the character lcd bus writer
// ---------------------------------------------------------------------------
package lcdbw_pkg;

  // input operation codes
  localparam logic [1:0] MODE_CMD    = 2'd0;
  localparam logic [1:0] MODE_DATA   = 2'd1;
  localparam logic [1:0] MODE_SINGLE = 2'd2;
  localparam logic [1:0] MODE_INIT   = 2'd3;

  // configuration register indexes
  localparam logic [2:0] CFG_BUS_EIGHT_BIT    = 3'd0;
  localparam logic [2:0] CFG_TWO_LINE         = 3'd1;
  localparam logic [2:0] CFG_FONT_TALL        = 3'd2;
  localparam logic [2:0] CFG_CURSOR_INCREMENT = 3'd3;
  localparam logic [2:0] CFG_SHIFT_DISPLAY    = 3'd4;
  localparam logic [2:0] CFG_SHOW_CURSOR      = 3'd5;
  localparam logic [2:0] CFG_CURSOR_BLINK     = 3'd6;

  // command bytes used by the init run
  localparam logic [7:0] LCD_RESET_BYTE = 8'h30;
  localparam logic [7:0] LCD_FSET_BASE  = 8'h20;
  localparam logic [7:0] LCD_ENTRY_BASE = 8'h04;
  localparam logic [7:0] LCD_DISP_BASE  = 8'h0C;
  localparam logic [7:0] LCD_CLEAR      = 8'h01;

  // extra hold after particular strobes
  localparam logic [2:0] WAIT_RST0  = 3'd5;
  localparam logic [2:0] WAIT_RST   = 3'd1;
  localparam logic [2:0] WAIT_CLEAR = 3'd3;

  // strobe phases: setup, enable high, enable low
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RST0,
    S_RST1,
    S_RST2,
    S_NIB,
    S_FSET,
    S_ENTRY,
    S_DISP,
    S_CLEAR,
    S_BYTE,
    S_SINGLE
  } seq_state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] value;
    logic [2:0] post_wait;
  } lcd_in_t;

  typedef struct packed {
    logic       pin_enable;
    logic       pin_select;
    logic [7:0] bus_value;
    logic [3:0] hold_units;
    logic       last;
  } lcd_out_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       emit;
    seq_state_t step;
    logic [1:0] phase;
    logic       lo_nibble;
    logic       strobe_final;
    logic       last;
  } lcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slot_free;
    logic eight_bit;
  } lcd_sts_t;

endpackage

/* rtl/char_lcd_bus_writer_core.sv */
// ---------------------------------------------------------------------------
// char_lcd_bus_writer_core
// character lcd bus writer, 4-bit or 8-bit parallel bus
// ---------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_word): one word per bus operation,
//   command byte, data byte, single-strobe command or the full init run
//   out channel (out_valid/out_ready/out_word): one pin state per word
//   (E, RS, DB7..DB0, hold in wait units), last marks the end of a run
//   cfg port: cfg_write/cfg_index/cfg_data, write only while idle
// timing
//   a strobe is three pin states; the sequencer builds one state per cycle,
//   while the output register has room, into that register, so the first
//   state shows once the run has started and that register has loaded it
//   a byte op is longer on a 4-bit bus than on an 8-bit bus, as is init;
//   each run also spends its intake step before its first state
//   in_ready is high only while the sequencer has no run in progress; the
//   last state of a run may still sit in the output register
// reset
//   config returns to 4-bit bus, two lines, cursor increment; the
//   sequencer goes idle and the output register empties
// stall
//   a low out_ready with a full output register freezes the sequencer; nothing is dropped
// ---------------------------------------------------------------------------
module char_lcd_bus_writer_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcdbw_pkg::lcd_in_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdbw_pkg::lcd_out_t out_word,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic                cfg_data
);
  import lcdbw_pkg::*;

  lcd_cmd_t cmd;
  lcd_sts_t sts;
  logic     idle;
  logic     start;

  // a new word is taken only between runs
  assign in_ready = idle;
  assign start    = in_valid && idle;

  // sequencer: which strobe, which phase, which nibble
  lcdbw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .start_mode (in_word.mode),
    .sts        (sts),
    .cmd        (cmd),
    .idle       (idle)
  );

  // config, item hold, pin state build, output register
  lcdbw_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // a taken word starts a run, so intake closes the next cycle
  a_intake_closes: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("intake still open after word taken");

  // enable high phase is never stretched
  a_enable_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.pin_enable |-> out_word.hold_units == 4'd1)
    else $error("enable pulse held more than one unit");

  // hold stays within one to eight units
  a_hold_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.hold_units != 4'd0) && (out_word.hold_units <= 4'd8))
    else $error("hold units out of range");

  // a run ends on an enable-low state
  a_last_low: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.last |-> !out_word.pin_enable)
    else $error("run ended with enable high");

endmodule

/* rtl/lcdbw_ctrl.sv */
// ---------------------------------------------------------------------------
// lcdbw_ctrl
// sequencer: walks the strobes of one run, three pin states per strobe
// ---------------------------------------------------------------------------
module lcdbw_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          start_mode,
  input  lcdbw_pkg::lcd_sts_t sts,
  output lcdbw_pkg::lcd_cmd_t cmd,
  output logic                idle
);
  import lcdbw_pkg::*;

  seq_state_t state, state_next;
  logic [1:0] phase, phase_next;
  logic       lo_nibble, lo_nibble_next;
  logic       emit;
  logic       byte_step;
  logic       strobe_final;
  logic       strobe_done;

  assign emit      = (state != S_IDLE) && sts.slot_free;
  assign byte_step = (state == S_FSET) || (state == S_ENTRY) || (state == S_DISP) ||
                     (state == S_CLEAR) || (state == S_BYTE);
  // a byte strobe ends its byte in 8-bit mode or on the low nibble
  assign strobe_final = byte_step ? (sts.eight_bit || lo_nibble) : 1'b1;
  assign strobe_done  = emit && (phase == PH_LOW) && strobe_final;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_SETUP;
      lo_nibble <= 1'b0;
    end else begin
      state     <= state_next;
      phase     <= phase_next;
      lo_nibble <= lo_nibble_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (start_mode)
            MODE_INIT:   state_next = S_RST0;
            MODE_SINGLE: state_next = S_SINGLE;
            MODE_CMD,
            MODE_DATA:   state_next = S_BYTE;
            default:     state_next = S_BYTE;
          endcase
        end
      end
      S_RST0:   if (strobe_done) state_next = S_RST1;
      S_RST1:   if (strobe_done) state_next = S_RST2;
      S_RST2:   if (strobe_done) state_next = sts.eight_bit ? S_FSET : S_NIB;
      S_NIB:    if (strobe_done) state_next = S_FSET;
      S_FSET:   if (strobe_done) state_next = S_ENTRY;
      S_ENTRY:  if (strobe_done) state_next = S_DISP;
      S_DISP:   if (strobe_done) state_next = S_CLEAR;
      S_CLEAR,
      S_BYTE,
      S_SINGLE: if (strobe_done) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // phase and nibble counters
  always_comb begin
    phase_next     = phase;
    lo_nibble_next = lo_nibble;
    if (start) begin
      phase_next     = PH_SETUP;
      lo_nibble_next = 1'b0;
    end else if (emit) begin
      if (phase == PH_LOW) begin
        phase_next     = PH_SETUP;
        lo_nibble_next = !strobe_final;
      end else begin
        phase_next = phase + 2'd1;
      end
    end
  end

  // outputs
  always_comb begin
    idle             = (state == S_IDLE);
    cmd.load         = start;
    cmd.emit         = emit;
    cmd.step         = state;
    cmd.phase        = phase;
    cmd.lo_nibble    = lo_nibble;
    cmd.strobe_final = strobe_final;
    cmd.last         = strobe_final && (phase == PH_LOW) &&
                       ((state == S_CLEAR) || (state == S_BYTE) || (state == S_SINGLE));
  end

endmodule

/* rtl/lcdbw_datapath.sv */
// ---------------------------------------------------------------------------
// lcdbw_datapath
// config registers, item register, pin state builder and output register
// ---------------------------------------------------------------------------
module lcdbw_datapath (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic                cfg_data,
  input  lcdbw_pkg::lcd_in_t  in_word,
  input  lcdbw_pkg::lcd_cmd_t cmd,
  output lcdbw_pkg::lcd_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output lcdbw_pkg::lcd_out_t out_word
);
  import lcdbw_pkg::*;

  logic    bus_eight_bit, two_line, font_tall, cursor_increment;
  logic    shift_display, show_cursor, cursor_blink;
  lcd_in_t item;
  logic [7:0] step_byte;
  logic [7:0] bus;
  logic [2:0] extra;
  logic [3:0] hold;
  logic       byte_step;
  lcd_out_t   word_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      bus_eight_bit    <= 1'b0;
      two_line         <= 1'b1;
      font_tall        <= 1'b0;
      cursor_increment <= 1'b1;
      shift_display    <= 1'b0;
      show_cursor      <= 1'b0;
      cursor_blink     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BUS_EIGHT_BIT:    bus_eight_bit    <= cfg_data;
        CFG_TWO_LINE:         two_line         <= cfg_data;
        CFG_FONT_TALL:        font_tall        <= cfg_data;
        CFG_CURSOR_INCREMENT: cursor_increment <= cfg_data;
        CFG_SHIFT_DISPLAY:    shift_display    <= cfg_data;
        CFG_SHOW_CURSOR:      show_cursor      <= cfg_data;
        CFG_CURSOR_BLINK:     cursor_blink     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= in_word;
  end

  // byte carried by the current step
  always_comb begin
    byte_step = 1'b0;
    extra     = 3'd0;
    unique case (cmd.step)
      S_RST0: begin
        step_byte = LCD_RESET_BYTE;
        extra     = WAIT_RST0;
      end
      S_RST1, S_RST2: begin
        step_byte = LCD_RESET_BYTE;
        extra     = WAIT_RST;
      end
      S_NIB: step_byte = LCD_FSET_BASE;
      S_FSET: begin
        step_byte = LCD_FSET_BASE | {3'b000, bus_eight_bit, two_line, font_tall, 2'b00};
        byte_step = 1'b1;
      end
      S_ENTRY: begin
        step_byte = LCD_ENTRY_BASE | {6'b000000, cursor_increment, shift_display};
        byte_step = 1'b1;
      end
      S_DISP: begin
        step_byte = LCD_DISP_BASE | {6'b000000, show_cursor, cursor_blink};
        byte_step = 1'b1;
      end
      S_CLEAR: begin
        step_byte = LCD_CLEAR;
        extra     = WAIT_CLEAR;
        byte_step = 1'b1;
      end
      S_BYTE: begin
        step_byte = item.value;
        extra     = item.post_wait;
        byte_step = 1'b1;
      end
      S_SINGLE: begin
        step_byte = bus_eight_bit ? item.value : {item.value[3:0], 4'b0000};
        extra     = item.post_wait;
      end
      default: step_byte = 8'h00;
    endcase
  end

  always_comb begin
    if (byte_step && !bus_eight_bit) begin
      bus = cmd.lo_nibble ? {step_byte[3:0], 4'b0000} : {step_byte[7:4], 4'b0000};
    end else begin
      bus = step_byte;
    end
    hold = 4'd1;
    if ((cmd.phase == PH_LOW) && cmd.strobe_final) hold = 4'd1 + {1'b0, extra};
    word_next.pin_enable = (cmd.phase == PH_HIGH);
    word_next.pin_select = (cmd.step == S_BYTE) && (item.mode == MODE_DATA);
    word_next.bus_value  = bus;
    word_next.hold_units = hold;
    word_next.last       = cmd.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) out_word <= word_next;
  end

  assign sts.slot_free = !out_valid || out_ready;
  assign sts.eight_bit = bus_eight_bit;

endmodule

/* bench/tb.sv */
// ---------------------------------------------------------------------------
// tb
// self-checking bench for char_lcd_bus_writer_core: a driver feeds operation
// words from a queue, an in-bench predictor builds the pin states each word
// should produce, and a monitor checks every pin state in order while both
// sides idle and stall at random
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdbw_pkg::*;

  // index past the end of the register list, writes to it must do nothing
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  localparam int RANDOM_PHASES    = 6;
  localparam int WORDS_PER_PHASE  = 55;
  localparam int LONG_HOLD_AT     = 400;   // pin states seen before the long hold
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT      = 4000;

  // every input has a known level from time zero
  logic     clk       = 1'b0;
  logic     rst       = 1'b1;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  lcd_in_t  in_word   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  lcd_out_t out_word;
  logic     cfg_write = 1'b0;
  logic [2:0] cfg_index = CFG_BUS_EIGHT_BIT;
  logic     cfg_data  = 1'b0;

  char_lcd_bus_writer_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // bench copy of the bus settings, reset values first
  logic lcd_eight_bit = 1'b0;
  logic lcd_two_line  = 1'b1;
  logic lcd_font_tall = 1'b0;
  logic lcd_cur_inc   = 1'b1;
  logic lcd_shift     = 1'b0;
  logic lcd_show_cur  = 1'b0;
  logic lcd_blink     = 1'b0;

  lcd_in_t  pending_words[$];   // words waiting to be offered
  lcd_out_t expected_pins[$];   // pin states still owed by the dut

  int fail_count   = 0;
  int ops_taken    = 0;
  int inits_taken  = 0;
  int pins_checked = 0;
  int settings_run = 1;

  // ---------------------------------------------------------------------------
  // pin state predictor
  // ---------------------------------------------------------------------------
  function automatic void push_pin(logic e, logic rs, logic [7:0] bus, logic [3:0] hold);
    lcd_out_t p;
    p.pin_enable = e;
    p.pin_select = rs;
    p.bus_value  = bus;
    p.hold_units = hold;
    p.last       = 1'b0;
    expected_pins.push_back(p);
  endfunction

  // setup, enable high, enable low; any extra wait lands on the low phase
  function automatic void push_strobe(logic rs, logic [7:0] bus, logic [2:0] extra);
    push_pin(1'b0, rs, bus, 4'd1);
    push_pin(1'b1, rs, bus, 4'd1);
    push_pin(1'b0, rs, bus, 4'd1 + {1'b0, extra});
  endfunction

  // 4-bit bus: high nibble then low nibble, both on DB7..4
  function automatic void push_byte(logic rs, logic [7:0] b, logic [2:0] extra);
    if (lcd_eight_bit) begin
      push_strobe(rs, b, extra);
    end else begin
      push_strobe(rs, {b[7:4], 4'h0}, 3'd0);
      push_strobe(rs, {b[3:0], 4'h0}, extra);
    end
  endfunction

  function automatic void predict_run(lcd_in_t w);
    lcd_out_t tail;
    case (w.mode)
      MODE_CMD: begin
        push_byte(1'b0, w.value, w.post_wait);
      end
      MODE_DATA: begin
        push_byte(1'b1, w.value, w.post_wait);
      end
      MODE_SINGLE: begin
        push_strobe(1'b0, lcd_eight_bit ? w.value : {w.value[3:0], 4'h0}, w.post_wait);
      end
      default: begin
        // three reset strobes, the switch to 4-bit if needed, then function set, entry, display, clear
        push_strobe(1'b0, LCD_RESET_BYTE, WAIT_RST0);
        push_strobe(1'b0, LCD_RESET_BYTE, WAIT_RST);
        push_strobe(1'b0, LCD_RESET_BYTE, WAIT_RST);
        if (!lcd_eight_bit) push_strobe(1'b0, LCD_FSET_BASE, 3'd0);
        push_byte(1'b0, LCD_FSET_BASE | {3'b000, lcd_eight_bit, lcd_two_line,
                                         lcd_font_tall, 2'b00}, 3'd0);
        push_byte(1'b0, LCD_ENTRY_BASE | {6'b0, lcd_cur_inc, lcd_shift}, 3'd0);
        push_byte(1'b0, LCD_DISP_BASE | {6'b0, lcd_show_cur, lcd_blink}, 3'd0);
        push_byte(1'b0, LCD_CLEAR, WAIT_CLEAR);
      end
    endcase
    // mark the end of the run
    tail = expected_pins.pop_back();
    tail.last = 1'b1;
    expected_pins.push_back(tail);
  endfunction

  function automatic void check_pin(lcd_out_t got);
    lcd_out_t want;
    if (expected_pins.size() == 0) begin
      $error("pin state %h arrived with nothing expected", got);
      fail_count++;
    end else begin
      want = expected_pins.pop_front();
      if (got.pin_enable !== want.pin_enable) begin
        $error("pin_enable: expected %0d, got %0d", want.pin_enable, got.pin_enable);
        fail_count++;
      end
      if (got.pin_select !== want.pin_select) begin
        $error("pin_select: expected %0d, got %0d", want.pin_select, got.pin_select);
        fail_count++;
      end
      if (got.bus_value !== want.bus_value) begin
        $error("bus_value: expected %h, got %h", want.bus_value, got.bus_value);
        fail_count++;
      end
      if (got.hold_units !== want.hold_units) begin
        $error("hold_units: expected %0d, got %0d", want.hold_units, got.hold_units);
        fail_count++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        fail_count++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers queued words, random gap after each accepted word
  // ---------------------------------------------------------------------------
  int tx_gap  = 0;
  bit tx_calm = 1'b0;

  always @(posedge clk) begin : drive_words
    logic offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      offer = in_valid;
      if (in_valid && in_ready) begin
        predict_run(in_word);
        ops_taken++;
        if (in_word.mode == MODE_INIT) inits_taken++;
        // every so often switch between idling and back-to-back words
        if (ops_taken % 40 == 0) tx_calm = ($urandom_range(0, 2) == 0);
        tx_gap = tx_calm ? 0 : $urandom_range(0, 5);
        offer = 1'b0;
      end
      if (!offer) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          offer = 1'b1;
        end
      end
      // one assignment per edge so a held valid never glitches
      in_valid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each accepted pin state, stalls at random
  // ---------------------------------------------------------------------------
  int rx_stall = 0;
  bit rx_calm  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        check_pin(out_word);
        pins_checked++;
        if (pins_checked % 60 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        rx_stall = rx_calm ? 0 : $urandom_range(0, 5);
        // one long hold-off so the dut backs up and drops in_ready
        if (pins_checked == LONG_HOLD_AT) rx_stall = LONG_HOLD_CYCLES;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic cfg_put(logic [2:0] idx, logic bit_val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= bit_val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_BUS_EIGHT_BIT:    lcd_eight_bit = bit_val;
      CFG_TWO_LINE:         lcd_two_line  = bit_val;
      CFG_FONT_TALL:        lcd_font_tall = bit_val;
      CFG_CURSOR_INCREMENT: lcd_cur_inc   = bit_val;
      CFG_SHIFT_DISPLAY:    lcd_shift     = bit_val;
      CFG_SHOW_CURSOR:      lcd_show_cur  = bit_val;
      CFG_CURSOR_BLINK:     lcd_blink     = bit_val;
      default: ;            // out of range index, ignored by the dut too
    endcase
  endtask

  // bit 0 bus width, then N, F, I/D, S, C, B
  task automatic apply_setting(logic [6:0] s);
    cfg_put(CFG_BUS_EIGHT_BIT,    s[0]);
    cfg_put(CFG_TWO_LINE,         s[1]);
    cfg_put(CFG_FONT_TALL,        s[2]);
    cfg_put(CFG_CURSOR_INCREMENT, s[3]);
    cfg_put(CFG_SHIFT_DISPLAY,    s[4]);
    cfg_put(CFG_SHOW_CURSOR,      s[5]);
    cfg_put(CFG_CURSOR_BLINK,     s[6]);
    settings_run++;
  endtask

  function automatic void queue_word(logic [1:0] m, logic [7:0] v, logic [2:0] pw);
    lcd_in_t w;
    w.mode      = m;
    w.value     = v;
    w.post_wait = pw;
    pending_words.push_back(w);
  endfunction

  // init runs are long, keep them to about one word in ten
  function automatic void queue_random_word();
    int pick;
    logic [1:0] m;
    pick = $urandom_range(0, 19);
    if (pick < 2) m = MODE_INIT;
    else if (pick < 8) m = MODE_CMD;
    else if (pick < 14) m = MODE_DATA;
    else m = MODE_SINGLE;
    queue_word(m, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)));
  endfunction

  // block until every queued word is taken and every pin state has come back;
  // sampled between edges so a word just popped by the driver shows as valid
  task automatic wait_idle();
    while (pending_words.size() != 0 || in_valid || expected_pins.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int guard;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 4-bit bus, nibble splitting and field extremes
    queue_word(MODE_INIT,   8'h00, 3'd0);
    queue_word(MODE_CMD,    8'h00, 3'd0);
    queue_word(MODE_CMD,    8'hFF, 3'd7);
    queue_word(MODE_DATA,   8'hA5, 3'd3);
    queue_word(MODE_DATA,   8'h00, 3'd0);
    queue_word(MODE_DATA,   8'hFF, 3'd7);
    queue_word(MODE_SINGLE, 8'h0F, 3'd0);
    queue_word(MODE_SINGLE, 8'hF3, 3'd7);    // high nibble must be dropped
    queue_word(MODE_SINGLE, 8'h00, 3'd1);
    queue_word(MODE_INIT,   8'hFF, 3'd7);    // value and wait ignored by init
    wait_idle();

    // every register flipped from reset, 8-bit bus
    apply_setting(7'b1110101);
    cfg_put(CFG_UNUSED, 1'b1);               // must not disturb anything
    queue_word(MODE_INIT,   8'h5A, 3'd5);
    queue_word(MODE_CMD,    8'hFF, 3'd7);
    queue_word(MODE_DATA,   8'h00, 3'd0);
    queue_word(MODE_SINGLE, 8'hFF, 3'd7);
    queue_word(MODE_SINGLE, 8'h5A, 3'd2);
    queue_word(MODE_DATA,   8'h81, 3'd5);
    wait_idle();

    // random phases: all-ones, all-zeros, then random settings
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) apply_setting(7'h7F);
      else if (ph == 1) apply_setting(7'h00);
      else apply_setting(7'($urandom_range(0, 127)));
      if (ph == 3) cfg_put(CFG_UNUSED, 1'($urandom_range(0, 1)));
      for (int i = 0; i < WORDS_PER_PHASE; i++) queue_random_word();
      wait_idle();
    end

    // drain with a bound in case the dut stops short
    guard = 0;
    while (expected_pins.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_pins.size() != 0) begin
      $error("%0d pin states never arrived", expected_pins.size());
      fail_count++;
    end

    $display("covered %0d operations (%0d init runs) over %0d bus settings",
             ops_taken, inits_taken, settings_run);
    $display("checked %0d pin states, %0d mismatches", pins_checked, fail_count);
    if (fail_count == 0) begin
      $display("char_lcd_bus_writer_core test passed");
    end else begin
      $display("char_lcd_bus_writer_core test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("char_lcd_bus_writer_core test failed");
    $finish;
  end

endmodule
